FILE: rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Holds the controller-to-datapath command and status structures and the
// configuration register indexes. Depends on nothing.
`default_nettype none

package modexp_pkg;

  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd1;

  localparam int unsigned EXPONENT_RESET = 65537;

  typedef struct packed {
    logic load;     // capture the base and initialize the accumulator
    logic reduce;   // one step of base mod modulus
    logic prep;     // set up the running power and clear the products
    logic dbl;      // double both partial products
    logic add;      // conditionally add the multiplicands, shift multiplier
    logic update;   // write back products and advance the exponent
    logic finish;   // load the output register
  } modexp_cmd_t;

  typedef struct packed {
    logic special;   // exponent or modulus is zero, no iteration needed
    logic exp_last;  // no exponent bits remain above the current one
  } modexp_status_t;

endpackage

`default_nettype wire

FILE: rtl/modexp_datapath.sv
// Datapath of the modular exponentiation block: configuration registers,
// base reduction, two bit-serial modular multiplier lanes and the result
// register. Depends on modexp_pkg for command, status and register indexes.
`default_nettype none

module modexp_datapath #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [WORD_WIDTH-1:0]                cfg_data,
  input  wire  [WORD_WIDTH-1:0]                base_value,
  input  modexp_pkg::modexp_cmd_t              cmd,
  output modexp_pkg::modexp_status_t           status,
  output logic [WORD_WIDTH-1:0]                power_result
);

  localparam int unsigned W = WORD_WIDTH;

  logic [W-1:0] exponent;
  logic [W-1:0] modulus;
  logic [W-1:0] base_shift;  // base bits fed MSB first into the reduction
  logic [W-1:0] rem;         // running remainder of base mod modulus
  logic [W-1:0] acc;         // accumulator of the result
  logic [W-1:0] pw;          // running power of the base
  logic [W-1:0] exp_shift;   // exponent bits still to process
  logic [W-1:0] mplier;      // shared multiplier operand, MSB first
  logic [W-1:0] prod_acc;    // partial product acc * pw
  logic [W-1:0] prod_pw;     // partial product pw * pw
  logic [W:0]   rem_trial;
  logic [W:0]   rem_next;

  // (x + y) mod m for x, y < m.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                           input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  always_comb begin
    rem_trial = {rem, base_shift[W-1]};
    if (rem_trial >= {1'b0, modulus}) begin
      rem_next = rem_trial - {1'b0, modulus};
    end else begin
      rem_next = rem_trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= W'(modexp_pkg::EXPONENT_RESET);
      modulus  <= W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        modexp_pkg::REG_EXPONENT: exponent <= cfg_data;
        modexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_shift <= base_value;
      rem        <= '0;
      exp_shift  <= exponent;
      // The accumulator starts at 1 mod modulus.
      acc        <= (modulus == W'(1)) ? '0 : W'(1);
    end
    if (cmd.reduce) begin
      rem        <= rem_next[W-1:0];
      base_shift <= {base_shift[W-2:0], 1'b0};
    end
    if (cmd.prep) begin
      pw       <= rem;
      mplier   <= rem;
      prod_acc <= '0;
      prod_pw  <= '0;
    end
    if (cmd.dbl) begin
      prod_acc <= add_mod(prod_acc, prod_acc, modulus);
      prod_pw  <= add_mod(prod_pw, prod_pw, modulus);
    end
    if (cmd.add) begin
      if (mplier[W-1]) begin
        prod_acc <= add_mod(prod_acc, acc, modulus);
        prod_pw  <= add_mod(prod_pw, pw, modulus);
      end
      mplier <= {mplier[W-2:0], 1'b0};
    end
    if (cmd.update) begin
      if (exp_shift[0]) begin
        acc <= prod_acc;
      end
      pw        <= prod_pw;
      mplier    <= prod_pw;
      prod_acc  <= '0;
      prod_pw   <= '0;
      exp_shift <= {1'b0, exp_shift[W-1:1]};
    end
    if (cmd.finish) begin
      if (exponent == '0) begin
        power_result <= W'(1);
      end else if (modulus == '0) begin
        power_result <= '0;
      end else begin
        power_result <= acc;
      end
    end
  end

  always_comb begin
    status.special  = (exponent == '0) || (modulus == '0);
    status.exp_last = (exp_shift[W-1:1] == '0);
  end

endmodule

`default_nettype wire

FILE: rtl/modexp_ctrl.sv
// Controller of the modular exponentiation block: sequences base reduction,
// the square-and-multiply passes and the output handshake.
// Depends on modexp_pkg for the command and status structures.
`default_nettype none

module modexp_ctrl #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        base_valid,
  output logic                       base_stall,
  output logic                       result_valid,
  input  wire                        result_stall,
  input  modexp_pkg::modexp_status_t status,
  output modexp_pkg::modexp_cmd_t    cmd
);

  localparam int unsigned CW = $clog2(WORD_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PREP,
    ST_DBL,
    ST_ADD,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          accept;
  logic          out_free;

  assign base_stall = (state != ST_IDLE);
  assign accept     = base_valid && !base_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.reduce = (state == ST_REDUCE);
    cmd.prep   = (state == ST_PREP);
    cmd.dbl    = (state == ST_DBL);
    cmd.add    = (state == ST_ADD);
    cmd.update = (state == ST_UPDATE);
    cmd.finish = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      // A new result replacing the one just transferred keeps valid high.
      if (result_valid && !result_stall && !cmd.finish) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= CW'(WORD_WIDTH - 1);
            state <= status.special ? ST_FINISH : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (cnt == '0) begin
            state <= ST_PREP;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_PREP: begin
          cnt   <= CW'(WORD_WIDTH - 1);
          state <= ST_DBL;
        end
        ST_DBL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (cnt == '0) begin
            state <= ST_UPDATE;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= ST_DBL;
          end
        end
        ST_UPDATE: begin
          cnt   <= CW'(WORD_WIDTH - 1);
          state <= status.exp_last ? ST_FINISH : ST_DBL;
        end
        ST_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/modular_exponentiation.sv
// Modular exponentiation block: base^exponent mod modulus per item.
// Top level joining modexp_ctrl and modexp_datapath; uses modexp_pkg.
//
// Usage: program exponent (index 0) and modulus (index 1) through the cfg
// channel while the block is idle; cfg_ready is always high, so a write
// transfers whenever cfg_valid is high. Writes to other indexes are ignored.
// Each base_value transferred on the base channel yields one power_result.
// Sequence: accept the base, reduce it MSB first modulo the modulus, set up
// the running power, then for each exponent bit up to the highest set one
// run alternating doublings and additions and write back the products, and
// finally load the output register; a zero exponent or zero modulus skips
// straight from accepting the base to loading the output register. The two
// bit-serial modular multipliers square the power and multiply the
// accumulator side by side, one doubling or one addition per cycle.
// One item is in flight at a time; the next is taken once the
// current result sits in the output register, even if that is stalled.
// A stalled result holds its value. Reset restores exponent 65537 and
// modulus 1 and drops any item in progress.
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    base_valid,
  output logic                                   base_stall,
  input  wire  [WORD_WIDTH-1:0]                  base_value,
  output logic                                   result_valid,
  input  wire                                    result_stall,
  output logic [WORD_WIDTH-1:0]                  power_result,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [WORD_WIDTH-1:0]                  cfg_data
);

  modexp_pkg::modexp_cmd_t    cmd;
  modexp_pkg::modexp_status_t status;

  assign cfg_ready = 1'b1;

  modexp_ctrl #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .base_valid  (base_valid),
    .base_stall  (base_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status      (status),
    .cmd         (cmd)
  );

  modexp_datapath #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .base_value  (base_value),
    .cmd         (cmd),
    .status      (status),
    .power_result(power_result)
  );

endmodule

`default_nettype wire

FILE: rtl/modexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top.
// Depends only on the ports of modular_exponentiation.
`default_nettype none

module modexp_checker #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input wire                  clk,
  input wire                  rst,
  input wire                  base_valid,
  input wire                  base_stall,
  input wire                  result_valid,
  input wire                  result_stall,
  input wire [WORD_WIDTH-1:0] power_result
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // A transfer on the base channel makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (base_valid && !base_stall) |=> base_stall)
    else $error("block not busy after accepting a base");

  // A new result only appears at the end of a computation.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(base_stall))
    else $error("result appeared without a computation");

  // A stalled result stays and holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(power_result)))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation modexp_checker #(
  .WORD_WIDTH(WORD_WIDTH)
) u_modexp_checker (
  .clk         (clk),
  .rst         (rst),
  .base_valid  (base_valid),
  .base_stall  (base_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .power_result(power_result)
);

`default_nettype wire

FILE: tb/tb_modular_exponentiation.sv
// Self-checking testbench for modular_exponentiation: directed and random bases
// under a range of exponent/modulus keys, random base gaps and result stalls.
// Depends on modexp_pkg and the modular_exponentiation RTL.
`default_nettype none

module tb_modular_exponentiation;

  localparam int WORD_W = 32;
  localparam int BASE_COUNT = 280;
  localparam int PRESSURE_HOLD = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DRAIN_LIMIT = 50000;
  localparam logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
  localparam logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef enum {CHECK_OK, CHECK_WRONG, CHECK_UNEXPECTED} check_t;

  // Tracks the key registers and the powers still owed by the block.
  class power_scoreboard;
    word_t exponent_reg;
    word_t modulus_reg;
    word_t expected_powers[$];

    function void reset_keys();
      exponent_reg = modexp_pkg::EXPONENT_RESET;
      modulus_reg = 1;
      expected_powers.delete();
    endfunction

    function void write_key(logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] index, word_t data);
      if (index == modexp_pkg::REG_EXPONENT) begin
        exponent_reg = data;
      end else if (index == modexp_pkg::REG_MODULUS) begin
        modulus_reg = data;
      end
    endfunction

    function word_t predict_power(word_t base);
      bit [63:0] acc;
      bit [63:0] pw;
      bit [63:0] m;
      if (exponent_reg == '0) return 1;
      if (modulus_reg == '0) return 0;
      m = {32'd0, modulus_reg};
      acc = 1;
      pw = {32'd0, base} % m;
      for (int i = 0; i < WORD_W; i++) begin
        if (exponent_reg[i]) acc = (acc * pw) % m;
        pw = (pw * pw) % m;
      end
      return acc[WORD_W-1:0];
    endfunction

    function void note_base(word_t base);
      expected_powers.push_back(predict_power(base));
    endfunction

    function check_t check_power(word_t got, output word_t want);
      if (expected_powers.size() == 0) begin
        want = '0;
        return CHECK_UNEXPECTED;
      end
      want = expected_powers.pop_front();
      return (got == want) ? CHECK_OK : CHECK_WRONG;
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic base_valid;
  logic base_stall;
  word_t base_value;
  logic result_valid;
  logic result_stall;
  word_t power_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  word_t cfg_data;
  logic burst_req;

  power_scoreboard sb;
  int mismatch_count = 0;

  modular_exponentiation #(
    .WORD_WIDTH(WORD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .base_valid(base_valid),
    .base_stall(base_stall),
    .base_value(base_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .power_result(power_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Hold a base until the block takes it; gap cycles of idle follow.
  task automatic send_base(word_t value, int gap);
    base_valid <= 1'b1;
    base_value <= value;
    do @(posedge clk); while (base_stall);
    if (gap > 0) begin
      base_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] index, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering bases and wait until every owed power has been delivered.
  task automatic wait_drained();
    int guard;
    guard = 0;
    base_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_key(word_t exp_value, word_t mod_value);
    wait_drained();
    write_reg(modexp_pkg::REG_EXPONENT, exp_value);
    write_reg(modexp_pkg::REG_MODULUS, mod_value);
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) sb.write_key(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (!rst && base_valid && !base_stall) sb.note_base(base_value);
  end

  always @(posedge clk) begin
    word_t want;
    check_t status;
    if (!rst && result_valid && !result_stall) begin
      status = sb.check_power(power_result, want);
      if (status == CHECK_UNEXPECTED) begin
        report($sformatf("result %h transferred with none expected", power_result));
      end else if (status == CHECK_WRONG) begin
        report($sformatf("power_result %h, expected %h", power_result, want));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int r;
    int n;
    bit burst_done;
    burst_done = 1'b0;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (burst_req && !burst_done) begin
        burst_done = 1'b1;
        result_stall <= 1'b1;
        n = PRESSURE_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          result_stall <= 1'b0;
          n = $urandom_range(1, 20);
        end else if (r < 88) begin
          result_stall <= 1'b1;
          n = $urandom_range(1, 4);
        end else if (r < 97) begin
          result_stall <= 1'b1;
          n = $urandom_range(5, 40);
        end else begin
          result_stall <= 1'b1;
          n = $urandom_range(100, 600);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int sent;
    int count;
    int gap;
    int r;
    word_t new_exp;
    word_t new_mod;
    word_t base;
    bit first_phase;

    sb = new;
    sb.reset_keys();
    rst <= 1'b1;
    base_valid <= 1'b0;
    base_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= modexp_pkg::REG_EXPONENT;
    cfg_data <= '0;
    burst_req <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key: exponent 65537 with modulus 1 gives zero.
    send_base('0, 0);
    send_base('1, 1);
    // Zero exponent gives one, even for modulus 1.
    set_key('0, 32'd1);
    send_base(32'd5, 0);
    set_key('0, '1);
    send_base('1, 0);
    // Zero modulus.
    set_key(32'd3, '0);
    send_base(32'd7, 0);
    set_key('0, '0);
    send_base(32'd7, 0);
    // Full-width exponent and modulus; the all-ones base reduces to zero.
    set_key('1, '1);
    send_base('0, 0);
    send_base(32'd1, 0);
    send_base('1, 2);
    send_base(32'hFFFF_FFFE, 0);
    send_base(32'h1234_5678, 0);
    // Exponent one exposes the initial reduction of the base.
    set_key(32'd1, 32'hFFFF_FFFB);
    send_base('1, 0);
    send_base(32'hFFFF_FFFA, 0);
    set_key(32'd65537, 32'hFFFF_FFC5);
    send_base(32'd2, 0);
    send_base(32'hDEAD_BEEF, 0);
    set_key(32'd2, 32'h8000_0000);
    send_base('1, 0);
    // Writes to unused indexes must leave both keys alone.
    wait_drained();
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_base(32'h0000_FFFF, 0);

    sent = 0;
    first_phase = 1'b1;
    while (sent < BASE_COUNT) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: new_exp = '1;
        1: new_exp = '0;
        2, 3: new_exp = $urandom;
        4: new_exp = $urandom | 32'h8000_0000;
        default: new_exp = $urandom >> $urandom_range(20, 31);
      endcase
      case ($urandom_range(0, 9))
        0: new_mod = '1;
        1: new_mod = 32'd1;
        2: new_mod = 32'd2;
        3, 4, 5: new_mod = $urandom | 32'h8000_0000;
        default: new_mod = $urandom >> $urandom_range(0, 28);
      endcase
      if (new_mod == '0) new_mod = 32'd3;
      if ($urandom_range(0, 4) != 0) write_reg(modexp_pkg::REG_EXPONENT, new_exp);
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      end
      write_reg(modexp_pkg::REG_MODULUS, new_mod);
      if (first_phase) begin
        burst_req <= 1'b1;
        first_phase = 1'b0;
      end
      count = $urandom_range(8, 24);
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(0, 9))
          0: base = '0;
          1: base = '1;
          2: base = new_mod - 1;
          3: base = 32'd1;
          4, 5: base = $urandom % new_mod;
          default: base = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (r < 50) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 5);
        else if (r < 97) gap = $urandom_range(6, 40);
        else gap = $urandom_range(100, 500);
        send_base(base, gap);
        sent++;
      end
    end

    wait_drained();
    if (sb.pending() != 0) begin
      report($sformatf("%0d expected results never transferred", sb.pending()));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
